// File: hw/rtl/psa_pkg.sv
// Shared types, codes and constants of the aging priority scheduler.
package psa_pkg;

    localparam int unsigned SLOTS_DEF = 16;
    localparam logic [15:0] AGING_RESET = 16'd100;

    localparam logic [2:0] EV_ARRIVED = 3'd0;
    localparam logic [2:0] EV_IO_DONE = 3'd1;
    localparam logic [2:0] EV_DISPATCH = 3'd2;
    localparam logic [2:0] EV_BLOCKED = 3'd3;
    localparam logic [2:0] EV_TERMINATED = 3'd4;
    localparam logic [2:0] EV_REJECTED = 3'd5;

    localparam logic [1:0] PL_READY = 2'd0;
    localparam logic [1:0] PL_WAIT = 2'd1;
    localparam logic [1:0] PL_RUN = 2'd2;

    localparam logic KIND_ADMIT = 1'b0;
    localparam logic KIND_TICK = 1'b1;
    localparam logic [2:0] REG_AGING = 3'd0;

    typedef struct packed {
        logic [15:0] pid;
        logic [15:0] left;
        logic [15:0] slice;
        logic [15:0] io;
        logic [7:0]  prio_now;
        logic [7:0]  prio_base;
        logic [31:0] ready_since;
        logic [31:0] io_done;
        logic [31:0] order;
    } ent_t;

    typedef struct packed {
        logic [2:0]  ev;
        logic [15:0] pid;
        logic [7:0]  prio;
        logic [15:0] rem;
        logic [15:0] burst;
        logic [15:0] io;
        logic [31:0] t;
    } res_t;

    typedef struct packed {
        logic emit_req;
        logic flush_req;
    } out_ctl_t;

    typedef struct packed {
        logic can_emit;
        logic pend_valid;
    } out_sts_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADMIT,
        S_IO_RD,
        S_IO_CHK,
        S_IO_END,
        S_RUN,
        S_RUN_CHK,
        S_AGE_RD,
        S_AGE_CHK,
        S_AGE_WAIT,
        S_DISP,
        S_FLUSH
    } state_t;

endpackage

// File: hw/rtl/psa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module psa_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/psa_age.sv
// Aging unit: bit-serial quotient of wait time by aging period, clamped to 8 bits.
module psa_age
    import psa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] diff,
    input  logic [15:0] period,
    input  logic [7:0]  base,
    output logic        done,
    output logic [7:0]  prio,
    output logic        changed
);

    logic        busy_reg;
    logic        done_reg;
    logic [2:0]  k_reg;
    logic [23:0] r_reg;
    logic [7:0]  q_reg;
    logic        big_reg;
    logic [15:0] period_reg;
    logic [7:0]  base_reg;
    logic [24:0] dsh;
    logic        ge;

    always_comb
    begin
        dsh = {9'b0, period_reg} << k_reg;
        ge = {1'b0, r_reg} >= dsh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg <= 3'd7;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg - 3'd1;
                if (k_reg == 3'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= diff[23:0];
            q_reg <= 8'd0;
            big_reg <= diff[31:8] >= {8'b0, period};
            period_reg <= period;
            base_reg <= base;
        end
        else if (busy_reg)
        begin
            q_reg[k_reg] <= ge;
            if (ge)
            begin
                r_reg <= r_reg - dsh[23:0];
            end
        end
    end

    assign done = done_reg;
    assign changed = big_reg || (q_reg != 8'd0);
    assign prio = (big_reg || (q_reg >= base_reg)) ? 8'd0 : base_reg - q_reg;

endmodule

// File: hw/rtl/psa_out.sv
// Result stage: one held-back item to mark the last one, then the output register.
module psa_out
    import psa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  out_ctl_t ctl,
    input  res_t     emit_data,
    output out_sts_t sts,
    output logic     out_valid,
    input  logic     out_stall,
    output res_t     out_data,
    output logic     out_last
);

    logic pend_valid_reg;
    res_t pend_reg;
    logic out_valid_reg;
    res_t out_reg;
    logic out_last_reg;
    logic out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign sts.can_emit = !pend_valid_reg || out_free;
    assign sts.pend_valid = pend_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.emit_req && sts.can_emit)
            begin
                pend_valid_reg <= 1'b1;
                if (pend_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else if (out_valid_reg && !out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
            end
            else if (ctl.flush_req && pend_valid_reg && out_free)
            begin
                pend_valid_reg <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.emit_req && sts.can_emit)
        begin
            pend_reg <= emit_data;
            if (pend_valid_reg)
            begin
                out_reg <= pend_reg;
                out_last_reg <= 1'b0;
            end
        end
        else if (ctl.flush_req && pend_valid_reg && out_free)
        begin
            out_reg <= pend_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;
    assign out_last = out_last_reg;

endmodule

// File: hw/rtl/priority_scheduler_with_aging.sv
// Top level: slot-table scheduler with aging, sequencer, config port and result stage.
// Input channel (in_valid/in_stall) takes one item at a time: kind 0 admits a task,
// kind 1 is one clock tick. Results leave on out_valid/out_stall, last marks the
// final result of an item; an item that causes no result produces nothing.
// The task table lives in one RAM, one entry per slot; each slot is read in a read
// state and checked in the state after it (S_IO_RD/S_IO_CHK, S_AGE_RD/S_AGE_CHK).
// An admit passes S_ADMIT and S_FLUSH. A tick scans the table for I/O once per task
// that finishes I/O and once more, then for aging; each ready slot also waits in
// S_AGE_WAIT on the eight-step aging divider. in_stall is high while an item
// is being worked on. The final result of an item is held back one step so that
// last is known; a result waiting in the output register does not block the
// next input item, but a stalled receiver eventually holds the sequencer.
// Reset empties the table, zeroes the tick count and sets aging_period to 100.
// APB register 0 at address 0 is aging_period (0 acts as 1); write only when idle.
module priority_scheduler_with_aging
    import psa_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] proc_id,
    input  logic [15:0] exec_time,
    input  logic [15:0] slice_length,
    input  logic [15:0] io_wait,
    input  logic [7:0]  priority_req,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  event_res,
    output logic [15:0] out_proc_id,
    output logic [7:0]  out_priority,
    output logic [15:0] out_remaining,
    output logic [15:0] out_burst,
    output logic [15:0] out_io_wait,
    output logic [31:0] event_time,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = $clog2(SLOTS);
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    state_t         state_reg, state_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic           found_reg, found_next;
    logic [IW-1:0]  best_idx_reg, best_idx_next;
    ent_t           best_reg, best_next;
    ent_t           cur_reg, cur_next;
    logic [31:0]    clock_reg, clock_next;
    logic [31:0]    order_reg, order_next;
    logic           run_valid_reg, run_valid_next;
    logic [IW-1:0]  run_slot_reg, run_slot_next;
    logic [31:0]    run_end_reg, run_end_next;
    logic [15:0]    aging_reg;
    logic [SLOTS-1:0] used_reg;
    logic [1:0]     place_reg [SLOTS];
    ent_t           adm_reg;

    logic           ram_we;
    logic [IW-1:0]  ram_waddr;
    ent_t           ram_wdata;
    logic [IW-1:0]  ram_raddr;
    logic [$bits(ent_t)-1:0] ram_rdata;
    ent_t           rd;

    logic           set_used, clr_used, set_place;
    logic [IW-1:0]  slot_sel;
    logic [1:0]     place_val;

    logic           free_found;
    logic [IW-1:0]  free_idx;

    logic           div_start, div_done, div_changed;
    logic [7:0]     div_prio;
    logic [15:0]    period_eff;
    logic [7:0]     new_prio;
    logic           better;
    logic [15:0]    burst;

    out_ctl_t       octl;
    out_sts_t       osts;
    res_t           emit_data;
    res_t           out_data;
    logic [SLOTS-1:0] run_mask;

    psa_ram #(
        .WIDTH($bits(ent_t)),
        .DEPTH(SLOTS)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd = ent_t'(ram_rdata);
    assign period_eff = (aging_reg == 16'd0) ? 16'd1 : aging_reg;

    psa_age u_age (
        .clk(clk),
        .rst_n(rst_n),
        .start(div_start),
        .diff(clock_reg - rd.ready_since),
        .period(period_eff),
        .base(rd.prio_base),
        .done(div_done),
        .prio(div_prio),
        .changed(div_changed)
    );

    psa_out u_out (
        .clk(clk),
        .rst_n(rst_n),
        .ctl(octl),
        .emit_data(emit_data),
        .sts(osts),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .out_last(last)
    );

    assign event_res = out_data.ev;
    assign out_proc_id = out_data.pid;
    assign out_priority = out_data.prio;
    assign out_remaining = out_data.rem;
    assign out_burst = out_data.burst;
    assign out_io_wait = out_data.io;
    assign event_time = out_data.t;

    // config port
    assign pready = 1'b1;
    assign prdata = (paddr == REG_AGING) ? {16'b0, aging_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            aging_reg <= AGING_RESET;
        end
        else if (psel && penable && pwrite && (paddr == REG_AGING))
        begin
            aging_reg <= pwdata[15:0];
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx = IW'(i);
            end
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign new_prio = div_changed ? div_prio : cur_reg.prio_now;
    assign burst = (best_reg.slice < best_reg.left) ? best_reg.slice : best_reg.left;

    always_comb
    begin
        better = !found_reg || (new_prio < best_reg.prio_now) ||
                 ((new_prio == best_reg.prio_now) &&
                  ((cur_reg.left < best_reg.left) ||
                   ((cur_reg.left == best_reg.left) && (cur_reg.order < best_reg.order))));
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        found_next = found_reg;
        best_idx_next = best_idx_reg;
        best_next = best_reg;
        cur_next = cur_reg;
        clock_next = clock_reg;
        order_next = order_reg;
        run_valid_next = run_valid_reg;
        run_slot_next = run_slot_reg;
        run_end_next = run_end_reg;
        ram_we = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = cur_reg;
        ram_raddr = idx_reg;
        set_used = 1'b0;
        clr_used = 1'b0;
        set_place = 1'b0;
        slot_sel = idx_reg;
        place_val = PL_READY;
        div_start = 1'b0;
        octl.emit_req = 1'b0;
        octl.flush_req = 1'b0;
        emit_data = '0;
        emit_data.t = clock_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    found_next = 1'b0;
                    state_next = (kind == KIND_ADMIT) ? S_ADMIT : S_IO_RD;
                end
            end
            S_ADMIT:
            begin
                octl.emit_req = 1'b1;
                emit_data.pid = adm_reg.pid;
                emit_data.ev = free_found ? EV_ARRIVED : EV_REJECTED;
                if (osts.can_emit)
                begin
                    if (free_found)
                    begin
                        ram_we = 1'b1;
                        ram_waddr = free_idx;
                        ram_wdata = adm_reg;
                        ram_wdata.ready_since = clock_reg;
                        ram_wdata.order = order_reg;
                        set_used = 1'b1;
                        set_place = 1'b1;
                        slot_sel = free_idx;
                        place_val = PL_READY;
                        order_next = order_reg + 32'd1;
                    end
                    state_next = S_FLUSH;
                end
            end
            S_IO_RD:
            begin
                state_next = S_IO_CHK;
            end
            S_IO_CHK:
            begin
                if (used_reg[idx_reg] && (place_reg[idx_reg] == PL_WAIT) &&
                    (rd.io_done <= clock_reg) &&
                    (!found_reg || (rd.order < best_reg.order)))
                begin
                    found_next = 1'b1;
                    best_idx_next = idx_reg;
                    best_next = rd;
                end
                idx_next = idx_reg + 1'b1;
                state_next = (idx_reg == LAST_IDX) ? S_IO_END : S_IO_RD;
            end
            S_IO_END:
            begin
                if (found_reg)
                begin
                    octl.emit_req = 1'b1;
                    emit_data.ev = EV_IO_DONE;
                    emit_data.pid = best_reg.pid;
                    if (osts.can_emit)
                    begin
                        ram_we = 1'b1;
                        ram_waddr = best_idx_reg;
                        ram_wdata = best_reg;
                        ram_wdata.ready_since = clock_reg;
                        ram_wdata.order = order_reg;
                        set_place = 1'b1;
                        slot_sel = best_idx_reg;
                        place_val = PL_READY;
                        order_next = order_reg + 32'd1;
                        idx_next = '0;
                        found_next = 1'b0;
                        state_next = S_IO_RD;
                    end
                end
                else
                begin
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                ram_raddr = run_slot_reg;
                if (run_valid_reg && (clock_reg >= run_end_reg))
                begin
                    state_next = S_RUN_CHK;
                end
                else
                begin
                    idx_next = '0;
                    found_next = 1'b0;
                    state_next = S_AGE_RD;
                end
            end
            S_RUN_CHK:
            begin
                ram_raddr = run_slot_reg;
                octl.emit_req = 1'b1;
                emit_data.pid = rd.pid;
                if (rd.left == 16'd0)
                begin
                    emit_data.ev = EV_TERMINATED;
                end
                else
                begin
                    emit_data.ev = EV_BLOCKED;
                    emit_data.io = rd.io;
                end
                if (osts.can_emit)
                begin
                    slot_sel = run_slot_reg;
                    if (rd.left == 16'd0)
                    begin
                        clr_used = 1'b1;
                    end
                    else
                    begin
                        ram_we = 1'b1;
                        ram_waddr = run_slot_reg;
                        ram_wdata = rd;
                        ram_wdata.io_done = clock_reg + {16'b0, rd.io};
                        ram_wdata.order = order_reg;
                        set_place = 1'b1;
                        place_val = PL_WAIT;
                        order_next = order_reg + 32'd1;
                    end
                    run_valid_next = 1'b0;
                    idx_next = '0;
                    found_next = 1'b0;
                    state_next = S_AGE_RD;
                end
            end
            S_AGE_RD:
            begin
                state_next = S_AGE_CHK;
            end
            S_AGE_CHK:
            begin
                cur_next = rd;
                if (used_reg[idx_reg] && (place_reg[idx_reg] == PL_READY))
                begin
                    div_start = 1'b1;
                    state_next = S_AGE_WAIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg == LAST_IDX) ? S_DISP : S_AGE_RD;
                end
            end
            S_AGE_WAIT:
            begin
                if (div_done)
                begin
                    ram_we = 1'b1;
                    ram_wdata.prio_now = new_prio;
                    if (better)
                    begin
                        found_next = 1'b1;
                        best_idx_next = idx_reg;
                        best_next = cur_reg;
                        best_next.prio_now = new_prio;
                    end
                    idx_next = idx_reg + 1'b1;
                    state_next = (idx_reg == LAST_IDX) ? S_DISP : S_AGE_RD;
                end
            end
            S_DISP:
            begin
                if (!run_valid_reg && found_reg)
                begin
                    octl.emit_req = 1'b1;
                    emit_data.ev = EV_DISPATCH;
                    emit_data.pid = best_reg.pid;
                    emit_data.prio = best_reg.prio_now;
                    emit_data.rem = best_reg.left;
                    emit_data.burst = burst;
                    if (osts.can_emit)
                    begin
                        ram_we = 1'b1;
                        ram_waddr = best_idx_reg;
                        ram_wdata = best_reg;
                        ram_wdata.left = best_reg.left - burst;
                        ram_wdata.prio_base = best_reg.prio_now;
                        set_place = 1'b1;
                        slot_sel = best_idx_reg;
                        place_val = PL_RUN;
                        run_valid_next = 1'b1;
                        run_slot_next = best_idx_reg;
                        run_end_next = clock_reg + {16'b0, burst};
                        clock_next = clock_reg + 32'd1;
                        state_next = S_FLUSH;
                    end
                end
                else
                begin
                    clock_next = clock_reg + 32'd1;
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                octl.flush_req = 1'b1;
                if (!osts.pend_valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            found_reg <= 1'b0;
            clock_reg <= 32'd0;
            order_reg <= 32'd0;
            run_valid_reg <= 1'b0;
            run_slot_reg <= '0;
            run_end_reg <= 32'd0;
            used_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            found_reg <= found_next;
            clock_reg <= clock_next;
            order_reg <= order_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg <= run_slot_next;
            run_end_reg <= run_end_next;
            if (set_used)
            begin
                used_reg[slot_sel] <= 1'b1;
            end
            if (clr_used)
            begin
                used_reg[slot_sel] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg <= best_idx_next;
        best_reg <= best_next;
        cur_reg <= cur_next;
        if (set_place)
        begin
            place_reg[slot_sel] <= place_val;
        end
        if ((state_reg == S_IDLE) && in_valid)
        begin
            adm_reg.pid <= proc_id;
            adm_reg.left <= exec_time;
            adm_reg.slice <= slice_length;
            adm_reg.io <= io_wait;
            adm_reg.prio_now <= priority_req;
            adm_reg.prio_base <= priority_req;
            adm_reg.ready_since <= 32'd0;
            adm_reg.io_done <= 32'd0;
            adm_reg.order <= 32'd0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            run_mask[i] = used_reg[i] && (place_reg[i] == PL_RUN);
        end
    end

    a_run_slot_live: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> used_reg[run_slot_reg] && (place_reg[run_slot_reg] == PL_RUN))
        else $error("running slot is not a live running task");

    a_one_running: assert property (@(posedge clk) disable iff (!rst_n)
        run_valid_reg |-> $onehot(run_mask))
        else $error("more than one running task");

    a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !osts.pend_valid)
        else $error("held-back result left while idle");

    a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        (clock_reg != $past(clock_reg)) |-> (clock_reg == $past(clock_reg) + 32'd1) &&
        ($past(state_reg) == S_DISP))
        else $error("tick count moved outside the end of a tick");

endmodule
